FILE: hdl/cbsr_pkg.sv
// Shared types and constants for the cartridge bank-switch register block.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package cbsr_pkg;

    localparam int unsigned DATA_W     = 8;
    localparam int unsigned PORT_W     = 2;
    localparam int unsigned OUT_TDATA_W = 24;

    typedef enum logic [PORT_W-1:0] {
        PORT_CMD  = 2'd0,
        PORT_DATA = 2'd1,
        PORT_SEL  = 2'd2,
        PORT_NONE = 2'd3
    } port_t;

    localparam logic [7:0] SEL_FIRST = 8'h23;
    localparam logic [7:0] SEL_SPAN  = 8'h04;

    localparam logic [7:0] CMD_BASE_A = 8'h08;
    localparam logic [7:0] CMD_BASE_B = 8'h0A;
    localparam logic [7:0] CMD_BASE_C = 8'h0E;
    localparam logic [7:0] CMD_BASE_D = 8'h12;
    localparam logic [7:0] CMD_BASE_E = 8'h16;
    localparam logic [7:0] CMD_BASE_F = 8'h1A;
    localparam logic [7:0] CMD_BASE_G = 8'h1E;
    localparam logic [7:0] CMD_CHR0   = 8'h09;
    localparam logic [7:0] CMD_CHR1   = 8'h0B;
    localparam logic [7:0] CMD_CHR2_A = 8'h0C;
    localparam logic [7:0] CMD_CHR2_B = 8'h0D;
    localparam logic [7:0] CMD_CHR3   = 8'h0F;
    localparam logic [7:0] CMD_CHR4_A = 8'h10;
    localparam logic [7:0] CMD_CHR4_B = 8'h11;
    localparam logic [7:0] CMD_CHR5_A = 8'h14;
    localparam logic [7:0] CMD_CHR5_B = 8'h15;
    localparam logic [7:0] CMD_CHR6_A = 8'h18;
    localparam logic [7:0] CMD_CHR6_B = 8'h19;
    localparam logic [7:0] CMD_CHR7_A = 8'h1C;
    localparam logic [7:0] CMD_CHR7_B = 8'h1D;

    localparam logic [6:0] FIELD_EVEN_MASK = 7'h0E;
    localparam logic [6:0] FIELD_ODD_SET   = 7'h01;
    localparam logic [6:0] FIELD_LOW_MASK  = 7'h0F;

    // packed from the top bit down, so prg_valid lands in bit 0
    typedef struct packed {
        logic [11:0] chr_bank;
        logic [2:0]  chr_window;
        logic        chr_valid;
        logic [3:0]  prg_bank;
        logic [1:0]  prg_window;
        logic        prg_valid;
    } result_t;

    function automatic logic [3:0] reverse_prg(input logic [7:0] d);
        return {d[2], d[3], d[4], d[5]};
    endfunction

endpackage

FILE: hdl/cartridge_bank_switch_registers_top.sv
// Bank-switch register block: port decode, select/command/base state, result register.
// Depends on cbsr_pkg.
// An input transfer passes the input register, then the result register, before its result shows on m_tvalid.
// Throughput: one transfer per cycle; both stages advance when the result register is free.
// Reset (aresetn low, synchronous): clears select, command and CHR base, empties both stages.
`timescale 1ns / 1ps

module cartridge_bank_switch_registers_top
    import cbsr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,   // [7:0] value
    input  logic [PORT_W-1:0]      s_tuser,   // [1:0] port
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [0] prg_valid, [2:1] prg_window,
                                              // [6:3] prg_bank, [7] chr_valid,
                                              // [10:8] chr_window, [22:11] chr_bank
);

    logic              in_valid_reg;
    logic [PORT_W-1:0] in_port_reg;
    logic [7:0]        in_value_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;
    result_t           out_data_next;

    logic [7:0] select_reg;
    logic [7:0] select_next;
    logic [7:0] command_reg;
    logic [7:0] command_next;
    logic [7:0] chr_base_reg;
    logic [7:0] chr_base_next;

    logic       advance;
    logic [7:0] sel_off;
    logic [6:0] half;
    logic [6:0] chr_field;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

    assign sel_off = select_reg - SEL_FIRST;
    assign half    = in_value_reg[7:1];

    always_comb begin
        select_next   = select_reg;
        command_next  = command_reg;
        chr_base_next = chr_base_reg;
        out_data_next = '0;
        chr_field     = '0;
        case (port_t'(in_port_reg))
            PORT_CMD: begin
                select_next  = '0;
                command_next = in_value_reg;
            end
            PORT_SEL: begin
                select_next  = in_value_reg;
                command_next = '0;
            end
            PORT_DATA: begin
                if (sel_off < SEL_SPAN) begin
                    out_data_next.prg_valid  = 1'b1;
                    out_data_next.prg_window = ~sel_off[1:0];
                    out_data_next.prg_bank   = reverse_prg(in_value_reg);
                end
                case (command_reg)
                    CMD_BASE_A, CMD_BASE_B, CMD_BASE_C, CMD_BASE_D,
                    CMD_BASE_E, CMD_BASE_F, CMD_BASE_G: begin
                        chr_base_next = in_value_reg;
                    end
                    CMD_CHR0: begin
                        out_data_next.chr_valid  = 1'b1;
                        out_data_next.chr_window = 3'd0;
                        chr_field = half & FIELD_EVEN_MASK;
                    end
                    CMD_CHR1: begin
                        out_data_next.chr_valid  = 1'b1;
                        out_data_next.chr_window = 3'd1;
                        chr_field = half | FIELD_ODD_SET;
                    end
                    CMD_CHR2_A, CMD_CHR2_B: begin
                        out_data_next.chr_valid  = 1'b1;
                        out_data_next.chr_window = 3'd2;
                        chr_field = half & FIELD_EVEN_MASK;
                    end
                    CMD_CHR3: begin
                        out_data_next.chr_valid  = 1'b1;
                        out_data_next.chr_window = 3'd3;
                        chr_field = half | FIELD_ODD_SET;
                    end
                    CMD_CHR4_A, CMD_CHR4_B: begin
                        out_data_next.chr_valid  = 1'b1;
                        out_data_next.chr_window = 3'd4;
                        chr_field = half & FIELD_LOW_MASK;
                    end
                    CMD_CHR5_A, CMD_CHR5_B: begin
                        out_data_next.chr_valid  = 1'b1;
                        out_data_next.chr_window = 3'd5;
                        chr_field = half & FIELD_LOW_MASK;
                    end
                    CMD_CHR6_A, CMD_CHR6_B: begin
                        out_data_next.chr_valid  = 1'b1;
                        out_data_next.chr_window = 3'd6;
                        chr_field = half & FIELD_LOW_MASK;
                    end
                    CMD_CHR7_A, CMD_CHR7_B: begin
                        out_data_next.chr_valid  = 1'b1;
                        out_data_next.chr_window = 3'd7;
                        chr_field = half & FIELD_LOW_MASK;
                    end
                    default: begin
                        chr_field = '0;
                    end
                endcase
                if (out_data_next.chr_valid) begin
                    out_data_next.chr_bank = {chr_base_reg, 4'h0} | {5'h00, chr_field};
                end
            end
            default: begin
                out_data_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            select_reg    <= '0;
            command_reg   <= '0;
            chr_base_reg  <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    select_reg   <= select_next;
                    command_reg  <= command_next;
                    chr_base_reg <= chr_base_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_port_reg  <= s_tuser;
            in_value_reg <= s_tdata;
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

FILE: hdl/cbsr_checker.sv
// Port-level checker for the bank-switch register block, bound to the top level.
// Depends on cbsr_pkg and cartridge_bank_switch_registers_top.
`timescale 1ns / 1ps

module cbsr_checker
    import cbsr_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [DATA_W-1:0]      s_tdata,
    input logic [PORT_W-1:0]      s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic unused_in;
    assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata) ^ (^s_tuser);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transfer changed");

    a_prg_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == 6'd0)
        else $error("PRG fields set without a PRG mapping");

    a_chr_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[7] |-> m_tdata[23:8] == 16'd0)
        else $error("CHR fields set without a CHR mapping");

    a_reset_empty: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind cartridge_bank_switch_registers_top cbsr_checker u_cbsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
